[hdl/hlr_pkg.sv]
// ----------------------------------------------------------------------------
// hlr_pkg
// Shared types and widths for the hex line rasteriser.
// ----------------------------------------------------------------------------
`default_nettype none

package hlr_pkg;

  localparam int COORD_W = 8;   // axial coordinate on the ports
  localparam int ACC_W   = 10;  // cube coordinate, s can reach 256
  localparam int DIST_W  = 9;   // raw hex distance, up to 510
  localparam int N_W     = 6;   // distance once within the limit (<= 63)
  localparam int DELTA_W = 8;   // per-step cube delta, |d| <= N

  typedef struct packed {
    logic signed [COORD_W-1:0] start_q;
    logic signed [COORD_W-1:0] start_r;
    logic signed [COORD_W-1:0] end_q;
    logic signed [COORD_W-1:0] end_r;
  } line_req_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] hex_q;
    logic signed [COORD_W-1:0] hex_r;
    logic                      last;
    logic                      too_far;
  } hex_item_t;

  // rounded coordinate of one lane and its rounding error (numerator over N)
  typedef struct packed {
    logic signed [ACC_W-1:0] rounded;
    logic [N_W-1:0]          err;
  } lane_res_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } state_t;

endpackage

`default_nettype wire

[hdl/hlr_chan_if.sv]
// ----------------------------------------------------------------------------
// hlr_chan_if
// Valid/ready channel carrying one payload per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface hlr_chan_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

`default_nettype wire

[hdl/hlr_lane.sv]
// ----------------------------------------------------------------------------
// hlr_lane
// One cube coordinate of the line. Holds the interpolated value as a floor
// quotient and remainder over N and steps it by its delta each hex, then
// rounds half away from zero and reports the rounding error.
// ----------------------------------------------------------------------------
`default_nettype none

module hlr_lane import hlr_pkg::*; (
  input  logic                      clk,
  input  logic                      init,
  input  logic                      step,
  input  logic signed [ACC_W-1:0]   start,
  input  logic signed [DELTA_W-1:0] delta,
  input  logic [N_W-1:0]            n,
  output lane_res_t                 res
);

  logic signed [ACC_W-1:0]   f;
  logic [N_W-1:0]            rem;
  logic signed [DELTA_W-1:0] d;

  logic signed [ACC_W-1:0]   f_next;
  logic [N_W-1:0]            rem_next;
  logic signed [DELTA_W:0]   t;
  logic signed [DELTA_W:0]   n_ext;
  logic [N_W:0]              twice;
  logic [N_W:0]              n_cmp;
  logic                      up;

  assign n_ext = $signed({{(DELTA_W+1-N_W){1'b0}}, n});
  assign t     = $signed({{(DELTA_W+1-N_W){1'b0}}, rem}) + (DELTA_W+1)'(d);

  // |d| <= N, so one correction keeps the remainder in [0, N)
  always_comb begin
    f_next   = f;
    rem_next = N_W'(t);
    if (t < 0) begin
      f_next   = f - ACC_W'(1);
      rem_next = N_W'(t + n_ext);
    end else if (t >= n_ext) begin
      f_next   = f + ACC_W'(1);
      rem_next = N_W'(t - n_ext);
    end
  end

  always_ff @(posedge clk) begin
    if (init) begin
      f   <= start;
      rem <= '0;
      d   <= delta;
    end else if (step) begin
      f   <= f_next;
      rem <= rem_next;
    end
  end

  // negative values take the tie downwards, i.e. away from zero
  assign twice = {rem, 1'b0};
  assign n_cmp = {1'b0, n};
  assign up    = (n != '0) && (f[ACC_W-1] ? (twice > n_cmp) : (twice >= n_cmp));

  assign res.rounded = f + $signed({{(ACC_W-1){1'b0}}, up});
  assign res.err     = up ? (n - rem) : rem;

endmodule

`default_nettype wire

[hdl/hex_line_rasterizer.sv]
// ----------------------------------------------------------------------------
// hex_line_rasterizer
// Draws a line of hexes between two axial hexes by exact cube interpolation
// and cube rounding, one hex per beat.
//
//   channel  dir  payload                          beat
//   ends     in   start_q, start_r, end_q, end_r   one line request
//   hexes    out  hex_q, hex_r, last, too_far      one hex of the line
//
// A line of distance N loads the three lanes when the request is accepted,
// then gives one hex per cycle while hexes does not stall, as the lanes step
// once per hex. Over-limit and zero-length lines give one beat.
// ends is not ready while a line is in progress. A stall on hexes holds
// the lanes. Synchronous reset clears the sequencer and output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module hex_line_rasterizer import hlr_pkg::*; #(
  parameter int MAX_DISTANCE = 63
) (
  input  logic       clk,
  input  logic       rst,
  hlr_chan_if.sink   ends,
  hlr_chan_if.source hexes
);

  state_t          state;
  logic [N_W-1:0]  n;
  logic [N_W-1:0]  cnt;
  logic            far;
  logic            ovalid;
  hex_item_t       opay;

  line_req_t       req;
  logic            accept;
  logic            out_free;
  logic            emit;
  logic            is_last;
  logic            step;

  logic signed [ACC_W-1:0]  aq, ar, as_c, bq, br;
  logic signed [ACC_W-1:0]  dq, dr, ds;
  logic [DIST_W-1:0]        adq, adr, ads, hex_dist;

  lane_res_t res_q, res_r, res_s;
  logic signed [ACC_W-1:0] hq, hr;

  assign req    = ends.payload;
  assign accept = ends.valid && ends.ready;
  assign ends.ready = (state == S_IDLE);

  // cube deltas and hex distance (max of the three absolute deltas)
  assign aq   = ACC_W'(req.start_q);
  assign ar   = ACC_W'(req.start_r);
  assign bq   = ACC_W'(req.end_q);
  assign br   = ACC_W'(req.end_r);
  assign as_c = -aq - ar;
  assign dq   = bq - aq;
  assign dr   = br - ar;
  assign ds   = -dq - dr;
  assign adq  = DIST_W'(dq[ACC_W-1] ? -dq : dq);
  assign adr  = DIST_W'(dr[ACC_W-1] ? -dr : dr);
  assign ads  = DIST_W'(ds[ACC_W-1] ? -ds : ds);

  always_comb begin
    hex_dist = adq;
    if (adr > hex_dist) hex_dist = adr;
    if (ads > hex_dist) hex_dist = ads;
  end

  assign out_free = !ovalid || hexes.ready;
  assign emit     = (state == S_RUN) && out_free;
  assign is_last  = far || (cnt == n);
  assign step     = emit && !is_last;

  hlr_lane u_lane_q (
    .clk(clk), .init(accept), .step(step), .start(aq),
    .delta(DELTA_W'(dq)), .n(n), .res(res_q)
  );
  hlr_lane u_lane_r (
    .clk(clk), .init(accept), .step(step), .start(ar),
    .delta(DELTA_W'(dr)), .n(n), .res(res_r)
  );
  hlr_lane u_lane_s (
    .clk(clk), .init(accept), .step(step), .start(as_c),
    .delta(DELTA_W'(ds)), .n(n), .res(res_s)
  );

  // rebuild the coordinate with the largest error; q only on a strict win,
  // and when s is the one rebuilt it is simply not emitted
  always_comb begin
    priority if (res_q.err > res_r.err && res_q.err > res_s.err) begin
      hq = -res_r.rounded - res_s.rounded;
      hr = res_r.rounded;
    end else if (res_r.err > res_s.err) begin
      hq = res_q.rounded;
      hr = -res_q.rounded - res_s.rounded;
    end else begin
      hq = res_q.rounded;
      hr = res_r.rounded;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      ovalid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) state <= S_RUN;
        end
        S_RUN: begin
          if (emit && is_last) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
      if (emit) begin
        ovalid <= 1'b1;
      end else if (hexes.ready) begin
        ovalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      far <= (hex_dist > DIST_W'(MAX_DISTANCE));
      n   <= N_W'(hex_dist);
      cnt <= '0;
    end else if (step) begin
      cnt <= cnt + N_W'(1);
    end
    if (emit) begin
      opay.last    <= is_last;
      opay.too_far <= far;
      opay.hex_q   <= far ? '0 : COORD_W'(hq);
      opay.hex_r   <= far ? '0 : COORD_W'(hr);
    end
  end

  assign hexes.valid   = ovalid;
  assign hexes.payload = opay;

  // ---- checks ----
  a_accept_runs: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_RUN))
    else $error("line accepted but sequencer not running");

  a_far_single: assert property (@(posedge clk) disable iff (rst)
    (hexes.valid && hexes.payload.too_far) |->
      (hexes.payload.last && hexes.payload.hex_q == '0 && hexes.payload.hex_r == '0))
    else $error("over-limit beat malformed");

  a_last_idles: assert property (@(posedge clk) disable iff (rst)
    (emit && is_last) |=> (state == S_IDLE && hexes.valid && hexes.payload.last))
    else $error("last hex did not end the line");

  a_no_step_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !step)
    else $error("lanes stepped while idle");

endmodule

`default_nettype wire
